### design/lps_pkg.sv
// lps_pkg: shared types and constants for the permutation stepper
// used by lps_seq and lexicographic_permutation_stepper
package lps_pkg;

  localparam int MAX_ITEMS    = 8;
  localparam int ELEMENT_BITS = 16;
  localparam int ADDR_W       = $clog2(MAX_ITEMS);
  localparam int CFG_W        = 4;

  localparam logic [CFG_W-1:0] ITEM_COUNT_RESET = CFG_W'(MAX_ITEMS);

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_NEXT = 2'd1;
  localparam logic [1:0] MODE_PREV = 2'd2;
  localparam logic [1:0] MODE_READ = 2'd3;

  typedef struct packed {
    logic [1:0]              mode;
    logic [ADDR_W-1:0]       load_index;
    logic [ELEMENT_BITS-1:0] element_value;
  } in_word_t;

  typedef struct packed {
    logic [ELEMENT_BITS-1:0] out_value;
    logic [ADDR_W-1:0]       out_position;
    logic                    last_of_row;
    logic                    found;
    logic                    has_next;
    logic                    has_prev;
  } out_word_t;

  typedef struct packed {
    logic                    we;
    logic [ADDR_W-1:0]       waddr;
    logic [ELEMENT_BITS-1:0] wdata;
    logic                    re;
    logic [ADDR_W-1:0]       raddr;
  } mem_req_t;

endpackage

### design/lps_ram.sv
// lps_ram: generic simple dual-port ram, one write and one registered read port
// no package dependencies
module lps_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/lps_seq.sv
// lps_seq: sequencer that scans, swaps, reverses and emits the row through the ram
// depends on lps_pkg
module lps_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  lps_pkg::in_word_t                 in_word,
  input  logic [lps_pkg::CFG_W-1:0]         item_count,
  input  logic [lps_pkg::ELEMENT_BITS-1:0]  rdata,
  output lps_pkg::mem_req_t                 mem_req,
  output logic                              busy,
  output logic                              emit,
  output lps_pkg::out_word_t                emit_word
);
  import lps_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PIV  = 3'd1;
  localparam logic [2:0] S_SUC  = 3'd2;
  localparam logic [2:0] S_SW   = 3'd3;
  localparam logic [2:0] S_RV   = 3'd4;
  localparam logic [2:0] S_FLG  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;
  localparam logic [1:0] PH_3 = 2'd3;

  logic [2:0]              state_r, state_nxt;
  logic                    fwd_r, fwd_nxt;
  logic                    found_r, found_nxt;
  logic                    asc_r, asc_nxt;
  logic                    desc_r, desc_nxt;
  logic [ADDR_W-1:0]       last_r, last_nxt;
  logic [ADDR_W-1:0]       idx_r, idx_nxt;
  logic                    iss_r, iss_nxt;
  logic                    dv_r, dv_nxt;
  logic [ADDR_W-1:0]       da_r, da_nxt;
  logic                    first_r, first_nxt;
  logic [ELEMENT_BITS-1:0] prev_r, prev_nxt;
  logic [ADDR_W-1:0]       piv_r, piv_nxt;
  logic [ELEMENT_BITS-1:0] pval_r, pval_nxt;
  logic [ADDR_W-1:0]       suc_r, suc_nxt;
  logic [ELEMENT_BITS-1:0] sval_r, sval_nxt;
  logic [ADDR_W-1:0]       lo_r, lo_nxt;
  logic [ADDR_W-1:0]       hi_r, hi_nxt;
  logic [1:0]              ph_r, ph_nxt;
  logic [ELEMENT_BITS-1:0] tmp_r, tmp_nxt;

  logic [ADDR_W-1:0] last_idx;
  logic              piv_hit, suc_hit, to_flg;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    if (item_count < CFG_W'(2)) begin
      last_idx = ADDR_W'(1);
    end else if (item_count > CFG_W'(MAX_ITEMS)) begin
      last_idx = ADDR_W'(MAX_ITEMS - 1);
    end else begin
      last_idx = ADDR_W'(item_count - CFG_W'(1));
    end
  end

  assign piv_hit = fwd_r ? (rdata < prev_r) : (rdata > prev_r);
  assign suc_hit = fwd_r ? (rdata > pval_r) : (rdata < pval_r);

  always_comb begin
    state_nxt = state_r;
    fwd_nxt   = fwd_r;
    found_nxt = found_r;
    asc_nxt   = asc_r;
    desc_nxt  = desc_r;
    last_nxt  = last_r;
    idx_nxt   = idx_r;
    iss_nxt   = iss_r;
    first_nxt = first_r;
    prev_nxt  = prev_r;
    piv_nxt   = piv_r;
    pval_nxt  = pval_r;
    suc_nxt   = suc_r;
    sval_nxt  = sval_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    ph_nxt    = ph_r;
    tmp_nxt   = tmp_r;
    to_flg    = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    emit      = 1'b0;
    emit_word = '0;
    mem_req   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_word.mode == MODE_LOAD) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = in_word.load_index;
            mem_req.wdata = in_word.element_value;
          end else begin
            last_nxt  = last_idx;
            fwd_nxt   = (in_word.mode == MODE_NEXT);
            found_nxt = 1'b0;
            if (in_word.mode == MODE_READ) begin
              to_flg = 1'b1;
            end else begin
              state_nxt = S_PIV;
              idx_nxt   = last_idx;
              iss_nxt   = 1'b1;
              first_nxt = 1'b1;
            end
          end
        end
      end
      S_PIV: begin
        rd_en = iss_r;
        if (iss_r) begin
          if (idx_r == '0) begin
            iss_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r - ADDR_W'(1);
          end
        end
        if (dv_r) begin
          if (!first_r && piv_hit) begin
            piv_nxt   = da_r;
            pval_nxt  = rdata;
            state_nxt = S_SUC;
            idx_nxt   = last_r;
            iss_nxt   = 1'b1;
          end else begin
            prev_nxt  = rdata;
            first_nxt = 1'b0;
            if (da_r == '0) begin
              to_flg = 1'b1;
            end
          end
        end
      end
      S_SUC: begin
        rd_en = iss_r;
        if (iss_r) begin
          if (idx_r == '0) begin
            iss_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r - ADDR_W'(1);
          end
        end
        if (dv_r && suc_hit) begin
          suc_nxt   = da_r;
          sval_nxt  = rdata;
          state_nxt = S_SW;
          iss_nxt   = 1'b0;
          ph_nxt    = PH_0;
        end
      end
      S_SW: begin
        mem_req.we = 1'b1;
        if (ph_r == PH_0) begin
          mem_req.waddr = piv_r;
          mem_req.wdata = sval_r;
          ph_nxt        = PH_1;
        end else begin
          mem_req.waddr = suc_r;
          mem_req.wdata = pval_r;
          found_nxt     = 1'b1;
          lo_nxt        = piv_r + ADDR_W'(1);
          hi_nxt        = last_r;
          if ({1'b0, piv_r} + (ADDR_W+1)'(1) < {1'b0, last_r}) begin
            state_nxt = S_RV;
            ph_nxt    = PH_0;
          end else begin
            to_flg = 1'b1;
          end
        end
      end
      S_RV: begin
        unique case (ph_r)
          PH_0: begin
            rd_en   = 1'b1;
            rd_addr = lo_r;
            ph_nxt  = PH_1;
          end
          PH_1: begin
            rd_en   = 1'b1;
            rd_addr = hi_r;
            tmp_nxt = rdata;
            ph_nxt  = PH_2;
          end
          PH_2: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = lo_r;
            mem_req.wdata = rdata;
            ph_nxt        = PH_3;
          end
          PH_3: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = hi_r;
            mem_req.wdata = tmp_r;
            lo_nxt        = lo_r + ADDR_W'(1);
            hi_nxt        = hi_r - ADDR_W'(1);
            ph_nxt        = PH_0;
            if (!({1'b0, lo_r} + (ADDR_W+1)'(2) < {1'b0, hi_r})) begin
              to_flg = 1'b1;
            end
          end
          default: ph_nxt = PH_0;
        endcase
      end
      S_FLG: begin
        rd_en = iss_r;
        if (iss_r) begin
          if (idx_r == last_r) begin
            iss_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + ADDR_W'(1);
          end
        end
        if (dv_r) begin
          if (!first_r) begin
            asc_nxt  = asc_r | (prev_r < rdata);
            desc_nxt = desc_r | (prev_r > rdata);
          end
          prev_nxt  = rdata;
          first_nxt = 1'b0;
          if (da_r == last_r) begin
            state_nxt = S_OUT;
            idx_nxt   = '0;
            iss_nxt   = 1'b1;
          end
        end
      end
      S_OUT: begin
        rd_en = iss_r;
        if (iss_r) begin
          if (idx_r == last_r) begin
            iss_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + ADDR_W'(1);
          end
        end
        if (dv_r) begin
          emit                   = 1'b1;
          emit_word.out_value    = rdata;
          emit_word.out_position = da_r;
          emit_word.last_of_row  = (da_r == last_r);
          emit_word.found        = found_r;
          emit_word.has_next     = asc_r;
          emit_word.has_prev     = desc_r;
          if (da_r == last_r) begin
            state_nxt = S_IDLE;
            iss_nxt   = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (to_flg) begin
      state_nxt = S_FLG;
      idx_nxt   = '0;
      iss_nxt   = 1'b1;
      first_nxt = 1'b1;
      asc_nxt   = 1'b0;
      desc_nxt  = 1'b0;
    end

    mem_req.re    = rd_en;
    mem_req.raddr = rd_addr;
  end

  // in-flight read data is dropped when the phase changes
  assign dv_nxt = rd_en && (state_nxt == state_r);
  assign da_nxt = rd_addr;
  assign busy   = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iss_r   <= 1'b0;
      dv_r    <= 1'b0;
      ph_r    <= PH_0;
    end else begin
      state_r <= state_nxt;
      iss_r   <= iss_nxt;
      dv_r    <= dv_nxt;
      ph_r    <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_r   <= fwd_nxt;
    found_r <= found_nxt;
    asc_r   <= asc_nxt;
    desc_r  <= desc_nxt;
    last_r  <= last_nxt;
    idx_r   <= idx_nxt;
    da_r    <= da_nxt;
    first_r <= first_nxt;
    prev_r  <= prev_nxt;
    piv_r   <= piv_nxt;
    pval_r  <= pval_nxt;
    suc_r   <= suc_nxt;
    sval_r  <= sval_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    tmp_r   <= tmp_nxt;
  end

endmodule

### design/lexicographic_permutation_stepper.sv
// lexicographic_permutation_stepper: top level with config register and result register
// depends on lps_pkg, lps_ram and lps_seq
//
// A command is taken when start is high and busy is low. A load writes one element in the
// accept cycle and gives no result. Next, prev and read keep busy high while the sequencer
// walks the row in the ram through its single read port. With n elements in use, a read
// runs the flag scan and the emission; a step runs the pivot scan and, if a pivot is found,
// the successor scan, the swap and the suffix reversal by pairs, then the flag scan and the
// emission. Results leave one per cycle on out_strobe/out_word, positions 0 to n-1, and
// cannot be held off. item_count is written over cfg, taken while busy is low; values below
// 2 act as 2, above 8 as 8.
module lexicographic_permutation_stepper (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  lps_pkg::in_word_t          in_word,
  output logic                       out_strobe,
  output lps_pkg::out_word_t         out_word,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lps_pkg::CFG_W-1:0]  cfg_data
);
  import lps_pkg::*;

  logic [CFG_W-1:0]        item_count_r;
  logic                    out_strobe_r;
  out_word_t               out_word_r;
  mem_req_t                mem_req;
  logic [ELEMENT_BITS-1:0] rdata;
  logic                    emit;
  out_word_t               emit_word;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r <= ITEM_COUNT_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        item_count_r <= cfg_data;
      end
      out_strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r <= emit_word;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  lps_ram #(
    .DATA_W (ELEMENT_BITS),
    .DEPTH  (MAX_ITEMS)
  ) u_row_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  lps_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_word    (in_word),
    .item_count (item_count_r),
    .rdata      (rdata),
    .mem_req    (mem_req),
    .busy       (busy),
    .emit       (emit),
    .emit_word  (emit_word)
  );

  a_strobe_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result word without an active command");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.last_of_row) |=> !out_strobe)
    else $error("result word right after the last word of a row");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.we && mem_req.re && (mem_req.waddr == mem_req.raddr)))
    else $error("ram read and write to the same entry in one cycle");

  a_cmd_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_word.mode != MODE_LOAD)) |=> busy)
    else $error("row command accepted without going busy");

endmodule
